@@ hw/rtl/irfe_pkg.sv @@
package irfe_pkg;

  localparam int MAX_SIDE_DEF = 256;

  localparam int COORD_W   = 8;
  localparam int SIZE_W    = 9;
  localparam int CHAN_W    = 8;
  localparam int RGB_W     = 3 * CHAN_W;
  localparam int NUM_W     = COORD_W + SIZE_W;
  localparam int IN_DATA_W = 2 * COORD_W + RGB_W;
  localparam int CFG_IDX_W = 3;

  // Quotient of a resample divide is below the source size, so SIZE_W steps.
  localparam int DIV_STEPS = SIZE_W;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
  localparam logic [CHAN_W-1:0] FILL_GREEN = 8'd255;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_IN_WIDTH,
    REG_IN_HEIGHT,
    REG_OUT_WIDTH,
    REG_OUT_HEIGHT
  } irfe_reg_t;

  typedef enum logic [1:0] {
    MODE_RESAMPLE,
    MODE_MIRROR_H,
    MODE_MIRROR_V,
    MODE_ROTATE
  } irfe_mode_t;

  // What the back end does with a queued request.
  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_READ,
    KIND_DIV,
    KIND_FILL
  } irfe_kind_t;

  typedef struct packed {
    irfe_mode_t          mode;
    logic [SIZE_W-1:0]   in_w;
    logic [SIZE_W-1:0]   in_h;
    logic [SIZE_W-1:0]   out_w;
    logic [SIZE_W-1:0]   out_h;
  } irfe_cfg_t;

  // a_num/b_num: column/row terms. Source coordinates for writes and direct
  // reads, dividends for resample reads. rgb is red in the lowest byte.
  typedef struct packed {
    irfe_kind_t          kind;
    logic [NUM_W-1:0]    a_num;
    logic [NUM_W-1:0]    b_num;
    logic [RGB_W-1:0]    rgb;
  } irfe_entry_t;

endpackage

@@ hw/rtl/irfe_front.sv @@
module irfe_front #(
  parameter int MAX_SIDE = irfe_pkg::MAX_SIDE_DEF
) (
  input  irfe_pkg::irfe_cfg_t             cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic [irfe_pkg::COORD_W-1:0]    col,
  input  logic [irfe_pkg::COORD_W-1:0]    row,
  input  logic [irfe_pkg::RGB_W-1:0]      rgb,
  input  logic                            q_full,
  output logic                            push,
  output irfe_pkg::irfe_entry_t           entry
);
  import irfe_pkg::*;

  logic [SIZE_W-1:0] col9;
  logic [SIZE_W-1:0] row9;
  logic              in_area;
  logic              wr_ok;

  assign col9  = SIZE_W'(col);
  assign row9  = SIZE_W'(row);
  assign wr_ok = (32'(col) < 32'(MAX_SIDE)) && (32'(row) < 32'(MAX_SIDE));

  always_comb begin
    entry       = '0;
    entry.rgb   = rgb;
    in_area     = 1'b0;
    if (op == OP_WRITE) begin
      entry.kind  = KIND_WRITE;
      entry.a_num = NUM_W'(col);
      entry.b_num = NUM_W'(row);
    end else begin
      case (cfg.mode)
        MODE_RESAMPLE: begin
          in_area     = (col9 < cfg.out_w) && (row9 < cfg.out_h);
          entry.a_num = NUM_W'(col) * NUM_W'(cfg.in_w);
          entry.b_num = NUM_W'(row) * NUM_W'(cfg.in_h);
        end
        MODE_MIRROR_H: begin
          in_area     = (col9 < cfg.in_w) && (row9 < cfg.in_h);
          entry.a_num = NUM_W'(cfg.in_w - 9'd1 - col9);
          entry.b_num = NUM_W'(row9);
        end
        MODE_MIRROR_V: begin
          in_area     = (col9 < cfg.in_w) && (row9 < cfg.in_h);
          entry.a_num = NUM_W'(col9);
          entry.b_num = NUM_W'(cfg.in_h - 9'd1 - row9);
        end
        default: begin
          in_area     = (col9 < cfg.in_h) && (row9 < cfg.in_w);
          entry.a_num = NUM_W'(row9);
          entry.b_num = NUM_W'(cfg.in_h - 9'd1 - col9);
        end
      endcase
      if (!in_area) begin
        entry.kind = KIND_FILL;
      end else if (cfg.mode == MODE_RESAMPLE) begin
        entry.kind = KIND_DIV;
      end else begin
        entry.kind = KIND_READ;
      end
    end
  end

  // Drop writes that fall outside the store: they never reach the queue.
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full && ((op != OP_WRITE) || wr_ok);

endmodule

@@ hw/rtl/irfe_queue.sv @@
module irfe_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  irfe_pkg::irfe_entry_t  push_entry,
  input  logic                   pop,
  output irfe_pkg::irfe_entry_t  head,
  output logic                   not_empty,
  output logic                   full
);
  import irfe_pkg::*;

  irfe_entry_t        q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;

  assign head      = q_mem[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == (Q_PTR_W + 1)'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count lost a push");

endmodule

@@ hw/rtl/irfe_div.sv @@
module irfe_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [irfe_pkg::NUM_W-1:0]    num,
  input  logic [irfe_pkg::SIZE_W-1:0]   den,
  output logic                          busy,
  output logic [irfe_pkg::SIZE_W-1:0]   quo
);
  import irfe_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  // Restoring division, one quotient bit a cycle. The dividend is known to be
  // below den << SIZE_W, so its upper bits seed the remainder directly.
  logic                busy_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SIZE_W-1:0]   rem_r;
  logic [SIZE_W-1:0]   low_r;
  logic [SIZE_W-1:0]   den_r;
  logic [SIZE_W:0]     trial;
  logic [SIZE_W-1:0]   rem_nxt;
  logic [SIZE_W-1:0]   low_nxt;
  logic                qbit;

  always_comb begin
    trial = {rem_r, low_r[SIZE_W-1]};
    qbit  = (trial >= {1'b0, den_r});
    if (qbit) begin
      rem_nxt = SIZE_W'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[SIZE_W-1:0];
    end
    low_nxt = {low_r[SIZE_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (cnt_r == CNT_W'(1))) begin
      busy_r <= 1'b0;
    end
    if (start) begin
      rem_r <= SIZE_W'(num[NUM_W-1:DIV_STEPS]);
      low_r <= num[DIV_STEPS-1:0];
      den_r <= den;
      cnt_r <= CNT_W'(DIV_STEPS);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign busy = busy_r;
  assign quo  = low_r;

endmodule

@@ hw/rtl/irfe_back.sv @@
module irfe_back #(
  parameter int MAX_SIDE = irfe_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  irfe_pkg::irfe_cfg_t           cfg,
  input  irfe_pkg::irfe_entry_t         head,
  input  logic                          q_valid,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [irfe_pkg::RGB_W-1:0]    out_rgb,
  output logic                          out_in_range
);
  import irfe_pkg::*;

  localparam int SW          = $clog2(MAX_SIDE);
  localparam int AW          = 2 * SW;
  localparam int STORE_DEPTH = 1 << AW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_RD
  } back_state_t;

  back_state_t         state_r;
  back_state_t         state_nxt;
  logic                out_valid_r;
  logic [RGB_W-1:0]    out_rgb_r;
  logic                out_in_range_r;

  logic [RGB_W-1:0]    store [STORE_DEPTH];
  logic [RGB_W-1:0]    rd_data_r;

  logic                out_free;
  logic                we;
  logic                re;
  logic                div_start;
  logic                load_fill;
  logic                load_pix;
  logic                busy_a;
  logic                busy_b;
  logic [SIZE_W-1:0]   quo_a;
  logic [SIZE_W-1:0]   quo_b;
  logic [SIZE_W-1:0]   src_c;
  logic [SIZE_W-1:0]   src_r;
  logic [SW-1:0]       sc;
  logic [SW-1:0]       sr;
  logic [AW-1:0]       addr;

  irfe_div u_div_col (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (head.a_num),
    .den   (cfg.out_w),
    .busy  (busy_a),
    .quo   (quo_a)
  );

  irfe_div u_div_row (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (head.b_num),
    .den   (cfg.out_h),
    .busy  (busy_b),
    .quo   (quo_b)
  );

  // Source coordinate: quotients after a divide, else the queued terms.
  // Saturate to the last store column or row.
  always_comb begin
    if (state_r == S_DIV) begin
      src_c = quo_a;
      src_r = quo_b;
    end else begin
      src_c = head.a_num[SIZE_W-1:0];
      src_r = head.b_num[SIZE_W-1:0];
    end
    sc   = (32'(src_c) >= 32'(MAX_SIDE)) ? SW'(MAX_SIDE - 1) : SW'(src_c);
    sr   = (32'(src_r) >= 32'(MAX_SIDE)) ? SW'(MAX_SIDE - 1) : SW'(src_r);
    addr = {sr, sc};
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    div_start = 1'b0;
    load_fill = 1'b0;
    load_pix  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          case (head.kind)
            KIND_WRITE: begin
              pop = 1'b1;
              we  = 1'b1;
            end
            KIND_READ: begin
              pop       = 1'b1;
              re        = 1'b1;
              state_nxt = S_RD;
            end
            KIND_DIV: begin
              pop       = 1'b1;
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
            KIND_FILL: begin
              if (out_free) begin
                pop       = 1'b1;
                load_fill = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (!busy_a) begin
          re        = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (out_free) begin
          load_pix  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_fill || load_pix) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (load_fill) begin
      out_rgb_r      <= {8'd0, FILL_GREEN, 8'd0};
      out_in_range_r <= 1'b0;
    end else if (load_pix) begin
      out_rgb_r      <= rd_data_r;
      out_in_range_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[addr] <= head.rgb;
    end
    if (re) begin
      rd_data_r <= store[addr];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_rgb      = out_rgb_r;
  assign out_in_range = out_in_range_r;

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    busy_a == busy_b) else $error("column and row dividers out of step");

  a_write_not_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> !busy_a) else $error("store write during a divide");

  a_pixel_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    load_pix |=> (out_valid_r && out_in_range_r))
    else $error("store pixel not flagged in range");

endmodule

@@ hw/rtl/image_remap_frame_engine.sv @@
// Frame store with a remapping read port.
//
// in_*  : stream of requests. in_tuser is the operation (0 write, 1 read);
//         in_tdata carries col, row and the colour of a write.
// out_* : one result per read request, none per write. out_tdata is the
//         pixel colour, out_tuser is the in-range flag; outside the output
//         area the colour is green (0,255,0) with the flag low.
// cfg_* : register writes, index 0 mode, 1..4 in/out width and height.
//         Always ready; write only while no request is in flight.
//
// A front stage classifies each request and forms the source terms, a
// four-entry queue decouples it from the back end, which owns the store.
// Writes retire one per cycle while the back end is idle. A mirror or rotate
// read passes the queue, the registered store read and the result register;
// a resample read first runs two restoring dividers, one quotient bit per cycle.
// The single store port serialises write, read and the registered read data.
// When out_tready is low the result register holds; reads and fills wait on
// it in the back end, and the queue keeps accepting until it fills.
// Reset clears the control state and the registers to mode 0, sizes 256;
// store contents are undefined until written.
module image_remap_frame_engine #(
  parameter int MAX_SIDE = irfe_pkg::MAX_SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] col, [15:8] row, [23:16] red_in, [31:24] green_in, [39:32] blue_in
  input  logic [irfe_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] operation
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out
  output logic [irfe_pkg::RGB_W-1:0]        out_tdata,
  // [0] in_range
  output logic                              out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [irfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irfe_pkg::SIZE_W-1:0]       cfg_data
);
  import irfe_pkg::*;

  irfe_cfg_t   cfg_r;
  irfe_entry_t push_entry;
  irfe_entry_t head;
  logic        push;
  logic        pop;
  logic        q_valid;
  logic        q_full;

  // Registers accept a write every cycle; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= MODE_RESAMPLE;
      cfg_r.in_w  <= SIZE_RESET;
      cfg_r.in_h  <= SIZE_RESET;
      cfg_r.out_w <= SIZE_RESET;
      cfg_r.out_h <= SIZE_RESET;
    end else if (cfg_valid) begin
      case (irfe_reg_t'(cfg_index))
        REG_MODE:       cfg_r.mode  <= irfe_mode_t'(cfg_data[1:0]);
        REG_IN_WIDTH:   cfg_r.in_w  <= cfg_data;
        REG_IN_HEIGHT:  cfg_r.in_h  <= cfg_data;
        REG_OUT_WIDTH:  cfg_r.out_w <= cfg_data;
        REG_OUT_HEIGHT: cfg_r.out_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify and form source terms (products for resample).
  irfe_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .op       (in_tuser),
    .col      (in_tdata[7:0]),
    .row      (in_tdata[15:8]),
    .rgb      (in_tdata[39:16]),
    .q_full   (q_full),
    .push     (push),
    .entry    (push_entry)
  );

  // Hold classified requests until the back end is free.
  irfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (q_valid),
    .full       (q_full)
  );

  // Divide, address the store, and register the result.
  irfe_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .head         (head),
    .q_valid      (q_valid),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_rgb      (out_tdata),
    .out_in_range (out_tuser)
  );

endmodule
